### design/ccb_pkg.sv
// shared types, character codes and the per-byte decision function for the comment blanker
`timescale 1ns / 1ps

package ccb_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_BLOCK  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] byte_val;
    mode_t      mode;
    logic       blank_next;
  } decision_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } out_entry_t;

  // decide one byte with its lookahead
  function automatic decision_t decide(input logic [1:0] mode, input logic [7:0] cur,
                                       input logic forced, input logic has_next,
                                       input logic [7:0] nxt);
    decision_t d;
    logic      next_slash;
    logic      next_star;
    next_slash   = has_next && (nxt == CH_SLASH);
    next_star    = has_next && (nxt == CH_STAR);
    d.byte_val   = cur;
    d.mode       = MODE_NORMAL;
    d.blank_next = 1'b0;
    case (mode)
      MODE_LINE: begin
        if (cur == CH_CR || cur == CH_LF) begin
          d.mode = MODE_NORMAL;
        end else begin
          d.mode     = MODE_LINE;
          d.byte_val = CH_SPACE;
        end
      end
      MODE_BLOCK: begin
        d.byte_val = CH_SPACE;
        if (cur == CH_STAR && next_slash) begin
          d.mode       = MODE_NORMAL;
          d.blank_next = 1'b1;
        end else begin
          d.mode = MODE_BLOCK;
        end
      end
      default: begin
        // normal text, also the unused code
        if (forced) begin
          d.byte_val = CH_SPACE;
        end else if (cur == CH_SLASH && next_slash) begin
          d.mode     = MODE_LINE;
          d.byte_val = CH_SPACE;
        end else if (cur == CH_SLASH && next_star) begin
          d.mode     = MODE_BLOCK;
          d.byte_val = CH_SPACE;
        end
      end
    endcase
    return d;
  endfunction

endpackage

### design/c_comment_blanker.sv
// top level of the comment blanker: lookahead register, decision logic and output queue
// Usage:
//   Raw script bytes enter on in_byte_in with in_last_byte marking the final
//   byte; a request is taken when in_valid and in_ready are both high.
//   Blanked bytes leave on out_byte_out with out_last_out on the final one,
//   taken when out_valid and out_ready are both high.
//   One byte is held back for lookahead, so the result for a byte appears
//   after the next request arrives; a request with in_last_byte set flushes
//   the held byte and itself, giving two results in one go.
//   Each accepted request is decided in the cycle it is taken and its results
//   enter a three-entry output queue; out_valid rises in the next cycle.
//   Throughput is one request per cycle while the receiver keeps up; the
//   queue drains one result per cycle, so a flush makes in_ready drop while its extra result drains.
//   in_ready is high while the queue holds at most one result and depends on
//   registers only. When the receiver stalls the queue fills and in_ready
//   drops until it drains.
//   Reset (rst_n low, synchronous) empties the queue, drops the held byte and
//   returns to normal-text mode. After a request with in_last_byte set the held
//   byte is dropped and normal-text mode restored, ready for the next script.
`timescale 1ns / 1ps

module c_comment_blanker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte_out,
  output logic       out_last_out
);

  logic [1:0]          mode_r, mode_nxt;
  logic [7:0]          held_byte_r, held_byte_nxt;
  logic                held_valid_r, held_valid_nxt;
  logic                held_blank_r, held_blank_nxt;
  ccb_pkg::out_entry_t q_r [3];
  ccb_pkg::out_entry_t q_nxt [3];
  logic [1:0]          cnt_r, cnt_nxt;

  logic                accept;
  logic                pop;
  ccb_pkg::decision_t  dec_held;
  ccb_pkg::decision_t  dec_last;
  logic [1:0]          mode_mid;
  logic                force_mid;
  ccb_pkg::out_entry_t res0, res1;
  logic                push0, push1;
  logic [1:0]          cnt_ap;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt_r <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte_out = q_r[0].byte_val;
  assign out_last_out = q_r[0].last;

  // held byte decided against the incoming byte, then the incoming byte on a flush
  always_comb begin
    dec_held  = ccb_pkg::decide(mode_r, held_byte_r, held_blank_r, 1'b1, in_byte_in);
    mode_mid  = held_valid_r ? dec_held.mode : mode_r;
    force_mid = held_valid_r && dec_held.blank_next;
    dec_last  = ccb_pkg::decide(mode_mid, in_byte_in, force_mid, 1'b0, 8'h00);
  end

  always_comb begin
    mode_nxt       = mode_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    held_blank_nxt = held_blank_r;
    if (accept) begin
      if (in_last_byte) begin
        mode_nxt       = ccb_pkg::MODE_NORMAL;
        held_byte_nxt  = 8'h00;
        held_valid_nxt = 1'b0;
        held_blank_nxt = 1'b0;
      end else begin
        mode_nxt       = mode_mid;
        held_byte_nxt  = in_byte_in;
        held_valid_nxt = 1'b1;
        held_blank_nxt = force_mid;
      end
    end
  end

  // results compacted into the first free queue slots
  always_comb begin
    res0.byte_val = held_valid_r ? dec_held.byte_val : dec_last.byte_val;
    res0.last     = !held_valid_r;
    res1.byte_val = dec_last.byte_val;
    res1.last     = 1'b1;
    push0         = accept && (held_valid_r || in_last_byte);
    push1         = accept && held_valid_r && in_last_byte;
  end

  always_comb begin
    cnt_ap = cnt_r - {1'b0, pop};
    for (int i = 0; i < 2; i++) begin
      if (pop) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push0 && (2'(i) == cnt_ap)) begin
        q_nxt[i] = res0;
      end else if (push1 && (2'(i) == cnt_ap + 2'd1)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = cnt_ap + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ccb_pkg::MODE_NORMAL;
      held_valid_r <= 1'b0;
      held_blank_r <= 1'b0;
      held_byte_r  <= 8'h00;
      cnt_r        <= 2'd0;
    end else begin
      mode_r       <= mode_nxt;
      held_valid_r <= held_valid_nxt;
      held_blank_r <= held_blank_nxt;
      held_byte_r  <= held_byte_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // queue never overflows its three slots
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 || !in_ready)
    else $error("queue full while accepting requests");

  // a flush leaves nothing held and normal mode
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> !held_valid_r && mode_r == ccb_pkg::MODE_NORMAL
      && !held_blank_r)
    else $error("state not cleared after flush");

  // a request that is not last is always held for lookahead
  a_hold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last_byte |=> held_valid_r && held_byte_r == $past(in_byte_in))
    else $error("accepted byte not held");

  // forced blank only follows a closed block comment
  a_blank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    held_blank_r |-> mode_r == ccb_pkg::MODE_NORMAL && held_valid_r)
    else $error("forced blank outside normal mode");

endmodule

### tb/c_comment_blanker_tb.sv
// self-checking testbench for the comment blanker: byte predictor, random scripts, random stalls
`timescale 1ns / 1ps
module c_comment_blanker_tb;

  localparam int HALF_PERIOD = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 1300;
  localparam int REPORT_MAX  = 10;

  // tracks comment mode and the lookahead byte, holds the blanked bytes still due
  class blank_predictor;
    ccb_pkg::mode_t      mode;
    logic [7:0]          held;
    logic                held_ok;
    logic                held_blank;
    ccb_pkg::out_entry_t blanked_q[$];
    int                  mismatches;
    int                  results;
    int                  line_opens;
    int                  block_opens;
    int                  forced_blanks;

    function new();
      clear();
      mismatches    = 0;
      results       = 0;
      line_opens    = 0;
      block_opens   = 0;
      forced_blanks = 0;
    endfunction

    function void clear();
      mode       = ccb_pkg::MODE_NORMAL;
      held       = '0;
      held_ok    = 1'b0;
      held_blank = 1'b0;
    endfunction

    // blank one byte given what follows it; moves the comment mode along
    function logic [7:0] judge(logic [7:0] cur, logic forced, logic have_next,
                               logic [7:0] nxt, output logic blank_next);
      blank_next = 1'b0;
      case (mode)
        ccb_pkg::MODE_LINE: begin
          if (cur == ccb_pkg::CH_CR || cur == ccb_pkg::CH_LF) begin
            mode = ccb_pkg::MODE_NORMAL;
            return cur;
          end
          return ccb_pkg::CH_SPACE;
        end
        ccb_pkg::MODE_BLOCK: begin
          if (cur == ccb_pkg::CH_STAR && have_next && nxt == ccb_pkg::CH_SLASH) begin
            mode       = ccb_pkg::MODE_NORMAL;
            blank_next = 1'b1;
          end
          return ccb_pkg::CH_SPACE;
        end
        default: begin
        end
      endcase
      mode = ccb_pkg::MODE_NORMAL;
      // slash that closes a block comment never opens a new one
      if (forced) begin
        forced_blanks++;
        return ccb_pkg::CH_SPACE;
      end
      if (cur == ccb_pkg::CH_SLASH && have_next && nxt == ccb_pkg::CH_SLASH) begin
        mode = ccb_pkg::MODE_LINE;
        line_opens++;
        return ccb_pkg::CH_SPACE;
      end
      if (cur == ccb_pkg::CH_SLASH && have_next && nxt == ccb_pkg::CH_STAR) begin
        mode = ccb_pkg::MODE_BLOCK;
        block_opens++;
        return ccb_pkg::CH_SPACE;
      end
      return cur;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      ccb_pkg::out_entry_t e;
      logic                blank_after;
      logic                ignored;
      blank_after = 1'b0;
      if (held_ok) begin
        e.byte_val = judge(held, held_blank, 1'b1, b, blank_after);
        e.last     = 1'b0;
        blanked_q.push_back(e);
      end
      if (last) begin
        // end of script: no lookahead, everything back to idle
        e.byte_val = judge(b, blank_after, 1'b0, 8'h00, ignored);
        e.last     = 1'b1;
        blanked_q.push_back(e);
        clear();
      end else begin
        held       = b;
        held_ok    = 1'b1;
        held_blank = blank_after;
      end
    endfunction

    function void check_blanked(logic [7:0] b, logic last);
      ccb_pkg::out_entry_t e;
      results++;
      if (blanked_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result %0d: byte_out %h last_out %b", results, b, last);
      end else begin
        e = blanked_q.pop_front();
        if (b !== e.byte_val || last !== e.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch on result %0d: byte_out exp %h got %h, last_out exp %b got %b",
                     results, e.byte_val, b, e.last, last);
        end
      end
    endfunction

    function int pending();
      return blanked_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte_in;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte_out;
  logic       out_last_out;

  blank_predictor pred = new();
  logic       tx_idle = 1'b1;
  logic       rx_idle = 1'b1;
  int         items_sent = 0;
  int         scripts_sent = 0;
  int         quiet_cycles = 0;
  logic [7:0] script_q[$];

  c_comment_blanker u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte_out (out_byte_out),
    .out_last_out (out_last_out)
  );

  always #HALF_PERIOD clk = ~clk;

  // requests first so a result never outruns its expectation
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_ready) begin
        pred.take_byte(in_byte_in, in_last_byte);
        quiet_cycles = 0;
      end
      if (out_valid && out_ready) begin
        pred.check_blanked(out_byte_out, out_last_out);
        quiet_cycles = 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_byte_in   = b;
    in_last_byte = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task send_script();
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    foreach (script_q[i]) send_byte(script_q[i], i == script_q.size() - 1);
    script_q.delete();
    scripts_sent++;
  endtask

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) script_q.push_back(s[i]);
  endfunction

  // biased toward the bytes the blanker reacts to
  function logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) return ccb_pkg::CH_SLASH;
    if (r < 32) return ccb_pkg::CH_STAR;
    if (r < 40) return ccb_pkg::CH_LF;
    if (r < 44) return ccb_pkg::CH_CR;
    if (r < 50) return ccb_pkg::CH_SPACE;
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  function void add_segment();
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 6)) script_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
      1: begin
        script_q.push_back(ccb_pkg::CH_SLASH);
        script_q.push_back(ccb_pkg::CH_SLASH);
        repeat ($urandom_range(0, 8)) script_q.push_back(pick_char());
        script_q.push_back($urandom_range(0, 1) ? ccb_pkg::CH_LF : ccb_pkg::CH_CR);
      end
      2: begin
        script_q.push_back(ccb_pkg::CH_SLASH);
        script_q.push_back(ccb_pkg::CH_STAR);
        repeat ($urandom_range(0, 8)) script_q.push_back(pick_char());
        script_q.push_back(ccb_pkg::CH_STAR);
        script_q.push_back(ccb_pkg::CH_SLASH);
        if ($urandom_range(0, 1)) script_q.push_back(ccb_pkg::CH_SLASH);
      end
      3: begin
        script_q.push_back(ccb_pkg::CH_SLASH);
        script_q.push_back(ccb_pkg::CH_STAR);
        script_q.push_back(ccb_pkg::CH_SLASH);
      end
      4: repeat ($urandom_range(1, 4)) script_q.push_back(pick_char());
      default: script_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte_in   = '0;
    in_last_byte = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // byte extremes
    script_q.push_back(8'h00);
    script_q.push_back(8'hFF);
    send_script();
    // line comment ended by LF, then by CR
    add_text("//x");
    script_q.push_back(ccb_pkg::CH_LF);
    add_text("y");
    send_script();
    add_text("//");
    script_q.push_back(ccb_pkg::CH_CR);
    add_text("z");
    send_script();
    // quick close
    add_text("/*/a");
    send_script();
    // closing slash of a block comment comes out blank; the slash right after it stays
    add_text("/**//x");
    send_script();
    // unterminated block comment
    add_text("/*a");
    send_script();
    // comment opened by the flushed byte, and a lone byte script
    add_text("//");
    send_script();
    add_text("/");
    send_script();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30))
          script_q.push_back($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) add_segment();
        if ($urandom_range(0, 4) == 0) begin
          // script ends inside a comment
          script_q.push_back(ccb_pkg::CH_SLASH);
          script_q.push_back($urandom_range(0, 1) ? ccb_pkg::CH_STAR : ccb_pkg::CH_SLASH);
          repeat ($urandom_range(0, 4)) script_q.push_back(pick_char());
        end
      end
      send_script();
    end
    in_valid = 1'b0;

    while (pred.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d scripts, %0d request bytes, %0d results", scripts_sent, items_sent,
             pred.results);
    $display("line comments %0d, block comments %0d, forced blank slashes %0d",
             pred.line_opens, pred.block_opens, pred.forced_blanks);
    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", pred.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/ccb_pkg.sv
design/c_comment_blanker.sv
tb/c_comment_blanker_tb.sv
